>>> rtl/wdm_pkg.sv
// shared types and constants for the waveshaper distortion mix core
// no dependencies
`default_nettype none

package wdm_pkg;

    localparam int AMT_W      = 17;
    localparam int WET_W      = 16;
    localparam int GAIN_W     = 32;
    localparam int GAIN_FRAC  = 16;
    localparam int MIX_SHIFT  = 15;

    localparam logic signed [AMT_W-1:0] AMT_LO = -17'sd32768;
    localparam logic signed [AMT_W-1:0] AMT_HI = 17'sd32768;
    localparam logic [WET_W-1:0]        WET_MAX = 16'h8000;

    // gain register holds 1 + k in q16.16
    localparam logic [GAIN_W-1:0] GAIN_UNITY   = 32'h0001_0000;
    localparam logic [GAIN_W-1:0] GAIN_AT_FULL = 32'd13172736;

    // serial gain divider: 34-bit dividend, one quotient bit per cycle
    localparam int KGEN_STEPS = 34;
    localparam int KGEN_CNT_W = $clog2(KGEN_STEPS + 1);

    typedef enum logic [0:0] {
        REG_SHAPING = 1'b0,
        REG_WET     = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic              busy;
        logic [GAIN_W-1:0] gain;
    } kgen_status_t;

endpackage

`default_nettype wire

>>> rtl/wdm_kgen.sv
// serial restoring divider deriving the shaping gain 1 + 2a/(1-a) in q16.16
// depends on wdm_pkg
`default_nettype none

module wdm_kgen (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               load,
    input  wire logic signed [wdm_pkg::AMT_W-1:0]   amount,
    output wdm_pkg::kgen_status_t                   status
);

    localparam int DEN_W = 17;
    localparam int DVD_W = wdm_pkg::KGEN_STEPS;

    logic                              busy_reg, busy_next;
    logic [wdm_pkg::KGEN_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DEN_W-1:0]                  rem_reg, rem_next;
    logic [DVD_W-1:0]                  quo_reg, quo_next;
    logic [DEN_W-1:0]                  den_reg, den_next;
    logic                              neg_reg, neg_next;
    logic                              special_reg, special_next;
    logic [wdm_pkg::GAIN_W-1:0]        gain_reg, gain_next;

    logic [DEN_W:0]                    den_wide;
    logic [DEN_W-1:0]                  amt_abs;
    logic [DVD_W-1:0]                  dividend;
    logic [DEN_W:0]                    rem_trial;
    logic                              rem_ge;
    logic [DVD_W-1:0]                  gain_full;

    always_comb
    begin
        // d = 1 - a scaled to q2.15, n = |2a| in q3.31 plus d/2 for rounding
        den_wide  = 18'sd32768 - (DEN_W+1)'(amount);
        amt_abs   = amount[wdm_pkg::AMT_W-1] ? DEN_W'(-amount) : DEN_W'(amount);
        dividend  = DVD_W'({amt_abs[15:0], 17'b0}) + DVD_W'(den_wide[DEN_W-1:1]);
        rem_trial = {rem_reg, quo_reg[DVD_W-1]};
        rem_ge    = rem_trial >= {1'b0, den_reg};
        gain_full = neg_reg ? (DVD_W'(wdm_pkg::GAIN_UNITY) - quo_reg)
                            : (DVD_W'(wdm_pkg::GAIN_UNITY) + quo_reg);
    end

    always_comb
    begin
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        den_next     = den_reg;
        neg_next     = neg_reg;
        special_next = special_reg;
        gain_next    = gain_reg;
        if (load)
        begin
            busy_next    = 1'b1;
            cnt_next     = wdm_pkg::KGEN_CNT_W'(wdm_pkg::KGEN_STEPS);
            rem_next     = '0;
            quo_next     = dividend;
            den_next     = den_wide[DEN_W-1:0];
            neg_next     = amount[wdm_pkg::AMT_W-1];
            special_next = (amount == wdm_pkg::AMT_HI);
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                rem_next = rem_ge ? DEN_W'(rem_trial - {1'b0, den_reg})
                                  : rem_trial[DEN_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], rem_ge};
                cnt_next = cnt_reg - 1'b1;
            end
            else
            begin
                gain_next = special_reg ? wdm_pkg::GAIN_AT_FULL
                                        : gain_full[wdm_pkg::GAIN_W-1:0];
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            gain_reg <= wdm_pkg::GAIN_UNITY;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            gain_reg <= gain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        den_reg     <= den_next;
        neg_reg     <= neg_next;
        special_reg <= special_next;
    end

    assign status.busy = busy_reg;
    assign status.gain = gain_reg;

endmodule

`default_nettype wire

>>> rtl/wdm_div.sv
// pipelined restoring fraction divider, one quotient bit per stage plus rounding
// no package dependencies
`default_nettype none

module wdm_div #(
    parameter int P_W    = 47,
    parameter int FRAC   = 15,
    parameter int SIDE_W = 17
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [P_W-1:0]    num,
    input  wire logic [P_W-1:0]    den,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [FRAC:0]          quo,
    output logic [SIDE_W-1:0]      side_out
);

    localparam int STAGES = FRAC + 2;
    localparam int Q_W    = FRAC + 2;

    logic              v_reg    [STAGES];
    logic [P_W-1:0]    r_reg    [STAGES];
    logic [P_W-1:0]    d_reg    [STAGES];
    logic [Q_W-1:0]    q_reg    [STAGES];
    logic [SIDE_W-1:0] side_reg [STAGES];

    logic              v_next    [STAGES];
    logic [P_W-1:0]    r_next    [STAGES];
    logic [P_W-1:0]    d_next    [STAGES];
    logic [Q_W-1:0]    q_next    [STAGES];
    logic [SIDE_W-1:0] side_next [STAGES];

    logic              v_in    [STAGES];
    logic [P_W-1:0]    r_in    [STAGES];
    logic [P_W-1:0]    d_in    [STAGES];
    logic [Q_W-1:0]    q_in    [STAGES];
    logic [SIDE_W-1:0] side_i  [STAGES];
    logic [P_W:0]      trial   [STAGES];
    logic              ge      [STAGES];

    always_comb
    begin
        v_in[0]   = in_valid;
        r_in[0]   = num;
        d_in[0]   = den;
        q_in[0]   = '0;
        side_i[0] = side_in;
        for (int j = 1; j < STAGES; j++)
        begin
            v_in[j]   = v_reg[j-1];
            r_in[j]   = r_reg[j-1];
            d_in[j]   = d_reg[j-1];
            q_in[j]   = q_reg[j-1];
            side_i[j] = side_reg[j-1];
        end
        for (int j = 0; j < STAGES; j++)
        begin
            // first stage yields the integer bit, the rest shift the remainder
            trial[j]     = (j == 0) ? {1'b0, r_in[j]} : {r_in[j], 1'b0};
            ge[j]        = trial[j] >= {1'b0, d_in[j]};
            r_next[j]    = ge[j] ? P_W'(trial[j] - {1'b0, d_in[j]}) : trial[j][P_W-1:0];
            q_next[j]    = {q_in[j][Q_W-2:0], ge[j]};
            v_next[j]    = v_in[j];
            d_next[j]    = d_in[j];
            side_next[j] = side_i[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < STAGES; j++)
            begin
                v_reg[j] <= 1'b0;
            end
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        d_reg    <= d_next;
        q_reg    <= q_next;
        side_reg <= side_next;
    end

    assign out_valid = v_reg[STAGES-1];
    assign quo       = (FRAC+1)'(q_reg[STAGES-1][Q_W-1:1]) + (FRAC+1)'(q_reg[STAGES-1][0]);
    assign side_out  = side_reg[STAGES-1];

endmodule

`default_nettype wire

>>> rtl/wdm_mix.sv
// wet/dry mix pipeline: sign restore, wet multiply, rounding and saturation
// depends on wdm_pkg
`default_nettype none

module wdm_mix #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic [SAMPLE_WIDTH-1:0]           shaped_mag,
    input  wire logic                              zero_den,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    dry,
    input  wire logic [wdm_pkg::WET_W-1:0]         wet,
    output logic                                   done,
    output logic signed [SAMPLE_WIDTH-1:0]         sample_out,
    output logic                                   clipped
);

    localparam int W      = SAMPLE_WIDTH;
    localparam int F      = W - 1;
    localparam int DIFF_W = W + 2;
    localparam int PROD_W = W + 19;
    localparam int RQ_W   = PROD_W - wdm_pkg::MIX_SHIFT;
    localparam int MIXV_W = RQ_W + 1;
    localparam int Y_W    = W + 6;

    localparam logic [PROD_W-1:0]      ROUND_HALF = PROD_W'(1) << (wdm_pkg::MIX_SHIFT - 1);
    localparam logic signed [Y_W-1:0]  Y_MAX      = {7'h00, {F{1'b1}}};
    localparam logic signed [Y_W-1:0]  Y_MIN      = {7'h7F, {F{1'b0}}};
    localparam logic signed [W-1:0]    OUT_MAX    = {1'b0, {F{1'b1}}};
    localparam logic signed [W-1:0]    OUT_MIN    = {1'b1, {F{1'b0}}};

    logic                      m1_v_reg, m2_v_reg, m3_v_reg, m4_v_reg, done_reg;
    logic signed [DIFF_W-1:0]  m1_diff_reg, m1_diff_next;
    logic signed [W-1:0]       m1_x_reg, m2_x_reg, m3_x_reg, m4_x_reg;
    logic                      m1_z_reg, m2_z_reg, m3_z_reg, m4_z_reg;
    logic signed [PROD_W-1:0]  m2_prod_reg, m2_prod_next;
    logic [PROD_W-1:0]         m3_mag_reg, m3_mag_next;
    logic                      m3_neg_reg;
    logic signed [MIXV_W-1:0]  m4_mix_reg, m4_mix_next;
    logic signed [W-1:0]       sample_out_reg, sample_out_next;
    logic                      clipped_reg, clipped_next;

    logic signed [W:0]         shaped;
    logic [PROD_W-1:0]         rounded;
    logic signed [MIXV_W-1:0]  rq;
    logic signed [Y_W-1:0]     y;

    always_comb
    begin
        shaped = zero_den ? '0
                          : (dry[W-1] ? -$signed({1'b0, shaped_mag})
                                      : $signed({1'b0, shaped_mag}));
        m1_diff_next = DIFF_W'(shaped) - DIFF_W'(dry);

        m2_prod_next = PROD_W'(m1_diff_reg) * PROD_W'($signed({1'b0, wet}));

        m3_mag_next = m2_prod_reg[PROD_W-1] ? PROD_W'(-m2_prod_reg) : PROD_W'(m2_prod_reg);

        rounded     = m3_mag_reg + ROUND_HALF;
        rq          = $signed({1'b0, rounded[PROD_W-1:wdm_pkg::MIX_SHIFT]});
        m4_mix_next = m3_neg_reg ? -rq : rq;

        y = Y_W'(m4_x_reg) + Y_W'(m4_mix_reg);
        if (y > Y_MAX)
        begin
            sample_out_next = OUT_MAX;
            clipped_next    = 1'b1;
        end
        else if (y < Y_MIN)
        begin
            sample_out_next = OUT_MIN;
            clipped_next    = 1'b1;
        end
        else
        begin
            sample_out_next = y[W-1:0];
            clipped_next    = m4_z_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            m3_v_reg <= 1'b0;
            m4_v_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            m1_v_reg <= in_valid;
            m2_v_reg <= m1_v_reg;
            m3_v_reg <= m2_v_reg;
            m4_v_reg <= m3_v_reg;
            done_reg <= m4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_diff_reg    <= m1_diff_next;
        m1_x_reg       <= dry;
        m1_z_reg       <= zero_den;
        m2_prod_reg    <= m2_prod_next;
        m2_x_reg       <= m1_x_reg;
        m2_z_reg       <= m1_z_reg;
        m3_mag_reg     <= m3_mag_next;
        m3_neg_reg     <= m2_prod_reg[PROD_W-1];
        m3_x_reg       <= m2_x_reg;
        m3_z_reg       <= m2_z_reg;
        m4_mix_reg     <= m4_mix_next;
        m4_x_reg       <= m3_x_reg;
        m4_z_reg       <= m3_z_reg;
        sample_out_reg <= sample_out_next;
        clipped_reg    <= clipped_next;
    end

    assign done       = done_reg;
    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

endmodule

`default_nettype wire

>>> rtl/waveshaper_distortion_mix_core.sv
// waveshaper distortion core: (1+k)x/(1+k|x|) shaping with wet/dry mix
// depends on wdm_pkg, wdm_kgen, wdm_div, wdm_mix
// One sample is taken per clock whenever start is high and busy is low, and its
// result appears on sample_out/clipped with a one-cycle done strobe after the
// front-end registers s1 to s3, the fraction divider and the mix registers m1 to
// m4 and done; the receiver cannot stall, so the output must be captured on done.
// The fraction divider resolves one quotient bit per pipeline stage. A write of
// the shaping amount starts the serial gain divider, and busy stays high until
// the new gain is loaded; writes of the wet ratio are registered and do not raise busy.
`default_nettype none

module waveshaper_distortion_mix_core #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    sample_in,
    input  wire logic                              wr_en,
    input  wire logic [0:0]                        wr_index,
    input  wire logic [wdm_pkg::AMT_W-1:0]         wr_data,
    output logic                                   done,
    output logic signed [SAMPLE_WIDTH-1:0]         sample_out,
    output logic                                   clipped
);

    localparam int W       = SAMPLE_WIDTH;
    localparam int F       = W - 1;
    localparam int P_W     = wdm_pkg::GAIN_W + F;
    localparam int MUL_W   = wdm_pkg::GAIN_W + W;
    localparam int LATENCY = 3 + (F + 2) + 5;

    localparam logic [W-1:0] ONE_X = W'(1) << F;

    wdm_pkg::kgen_status_t          kgen_status;
    wdm_pkg::cfg_reg_t              cfg_sel;
    logic [wdm_pkg::WET_W-1:0]      wet_reg, wet_next;
    logic                           amt_load;
    logic signed [wdm_pkg::AMT_W-1:0] amt_raw, amt_clamped;
    logic                           accept;

    logic                           s1_v_reg, s2_v_reg, s3_v_reg;
    logic signed [W-1:0]            s1_x_reg, s2_x_reg, s3_x_reg;
    logic [W-1:0]                   s1_ax_reg, s1_ax_next;
    logic [P_W-1:0]                 s2_ga_reg, s2_ga_next;
    logic [P_W-1:0]                 s2_h_reg, s2_h_next;
    logic                           s2_z_reg, s2_z_next, s3_z_reg;
    logic [P_W-1:0]                 s3_p_reg, s3_p_next, s3_n_reg;
    logic [MUL_W-1:0]               ga_full;

    logic                           div_valid;
    logic [F:0]                     div_quo;
    logic [W:0]                     div_side;

    // configuration decode
    always_comb
    begin
        cfg_sel  = wdm_pkg::cfg_reg_t'(wr_index);
        amt_raw  = $signed(wr_data);
        wet_next = wet_reg;
        amt_load = 1'b0;
        if (amt_raw < wdm_pkg::AMT_LO)
        begin
            amt_clamped = wdm_pkg::AMT_LO;
        end
        else if (amt_raw > wdm_pkg::AMT_HI)
        begin
            amt_clamped = wdm_pkg::AMT_HI;
        end
        else
        begin
            amt_clamped = amt_raw;
        end
        if (wr_en)
        begin
            unique case (cfg_sel)
                wdm_pkg::REG_SHAPING: amt_load = 1'b1;
                wdm_pkg::REG_WET:
                begin
                    wet_next = (wr_data[wdm_pkg::WET_W-1:0] > wdm_pkg::WET_MAX)
                             ? wdm_pkg::WET_MAX : wr_data[wdm_pkg::WET_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wet_reg <= wdm_pkg::WET_MAX;
        end
        else
        begin
            wet_reg <= wet_next;
        end
    end

    wdm_kgen u_kgen (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (amt_load),
        .amount (amt_clamped),
        .status (kgen_status)
    );

    assign busy   = kgen_status.busy | amt_load;
    assign accept = start & ~busy;

    // front end: magnitude, g*|x|, then denominator 2^16(1-|x|) + g|x|
    always_comb
    begin
        s1_ax_next = sample_in[W-1] ? (~sample_in + 1'b1) : sample_in;
        ga_full    = MUL_W'(kgen_status.gain) * MUL_W'(s1_ax_reg);
        s2_ga_next = ga_full[P_W-1:0];
        s2_h_next  = P_W'({ONE_X - s1_ax_reg, {wdm_pkg::GAIN_FRAC{1'b0}}});
        s2_z_next  = (kgen_status.gain == '0) && (s1_ax_reg == ONE_X);
        s3_p_next  = s2_h_reg + s2_ga_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= accept;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg  <= sample_in;
        s1_ax_reg <= s1_ax_next;
        s2_x_reg  <= s1_x_reg;
        s2_ga_reg <= s2_ga_next;
        s2_h_reg  <= s2_h_next;
        s2_z_reg  <= s2_z_next;
        s3_x_reg  <= s2_x_reg;
        s3_p_reg  <= s3_p_next;
        s3_n_reg  <= s2_ga_reg;
        s3_z_reg  <= s2_z_reg;
    end

    wdm_div #(
        .P_W    (P_W),
        .FRAC   (F),
        .SIDE_W (W + 1)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_v_reg),
        .num       (s3_n_reg),
        .den       (s3_p_reg),
        .side_in   ({s3_z_reg, s3_x_reg}),
        .out_valid (div_valid),
        .quo       (div_quo),
        .side_out  (div_side)
    );

    wdm_mix #(
        .SAMPLE_WIDTH (W)
    ) u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div_valid),
        .shaped_mag (div_quo),
        .zero_den   (div_side[W]),
        .dry        ($signed(div_side[W-1:0])),
        .wet        (wet_reg),
        .done       (done),
        .sample_out (sample_out),
        .clipped    (clipped)
    );

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted word did not complete at the pipeline latency");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("done without a matching accepted word");

    a_busy_on_amount: assert property (@(posedge clk) disable iff (!rst_n)
        amt_load |=> busy)
        else $error("gain update did not hold off new words");

endmodule

`default_nettype wire
